FILE: hdl/wlsc_pkg.sv
// Shared types and constants for the word list substring counter.
// No dependencies; imported by every module of the block.
package wlsc_pkg;

    // Default window depth (longest pattern in bytes)
    localparam int MAX_PATTERN_DEF = 16;

    // Field and register widths
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 5;
    localparam int PAT_W   = 64;
    localparam int COUNT_W = 16;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_CHAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_END    = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd2;

    // Per-cell control from the top level
    typedef struct packed {
        logic shift;   // load the neighbor's character (the input byte in cell 0) this cycle
        logic active;  // cell position falls inside the pattern length
    } t_cell_ctl;

endpackage

FILE: hdl/wlsc_cell.sv
// One window cell: holds one character, compares the incoming one with its pattern byte.
// Depends on wlsc_pkg.
module wlsc_cell import wlsc_pkg::*; (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [CHAR_W-1:0] i_pattern_byte,
    input  logic              i_match,
    output logic [CHAR_W-1:0] o_char,
    output logic              o_match
);

    logic [CHAR_W-1:0] r_char;

    // Shift register stage of the window
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_char <= i_char;
        end
    end

    // Compare the value this cell will hold after the shift; inactive cells pass
    assign o_match = i_match & (~i_ctl.active | (i_char == i_pattern_byte));
    assign o_char  = r_char;

endmodule

FILE: hdl/word_list_substring_counter_unit.sv
// Word list substring counter, top level.
// Depends on wlsc_pkg and wlsc_cell.
//
// The block takes one beat per clock: characters shift into a row of MAX_PATTERN
// cells that each compare their new character with one pattern byte in the same
// cycle, so a word's match flag is ready for an end-of-word beat right after its
// last character. A report beat loads a single result register; it is held back
// only while that register still holds a result the sink has not taken, and all
// other beats keep flowing meanwhile. There is no clearing pass after reset.
module word_list_substring_counter_unit import wlsc_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PAT_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic                 i_list_select,
    input  logic [CHAR_W-1:0]    i_char_byte,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_counts_equal,
    output logic [COUNT_W-1:0]   o_first_count,
    output logic [COUNT_W-1:0]   o_second_count
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATTERN);

    // Configuration registers
    logic [LEN_W-1:0]   r_pat_len;
    logic [PAT_W-1:0]   r_pat_lo;
    logic [PAT_W-1:0]   r_pat_hi;

    // Word and count state
    logic [CNT_W-1:0]   r_chars, n_chars;
    logic               r_word_matched, n_word_matched;
    logic [COUNT_W-1:0] r_first, n_first;
    logic [COUNT_W-1:0] r_second, n_second;

    // Result register
    logic               r_out_valid, n_out_valid;
    logic               r_out_eq;
    logic [COUNT_W-1:0] r_out_first;
    logic [COUNT_W-1:0] r_out_second;

    logic               w_accept;
    logic               w_is_char;
    logic               w_is_end;
    logic               w_is_report;
    logic [LEN_W-1:0]   w_len;
    logic [2*PAT_W-1:0] w_pattern;
    logic               w_hit;

    logic [CHAR_W-1:0]  w_cell_in [MAX_PATTERN];
    logic [CHAR_W-1:0]  w_cell_q  [MAX_PATTERN];
    logic               w_chain   [MAX_PATTERN+1];

    // Handshake: only a report needs room in the result register
    assign o_in_ready  = (i_opcode != OP_REPORT) | ~r_out_valid | i_out_ready;
    assign w_accept    = i_in_valid & o_in_ready;
    assign w_is_char   = w_accept & (i_opcode == OP_CHAR);
    assign w_is_end    = w_accept & (i_opcode == OP_END);
    assign w_is_report = w_accept & (i_opcode == OP_REPORT);

    // Effective pattern length, clamped to 1..MAX_PATTERN
    always_comb begin
        w_len = r_pat_len;
        if (r_pat_len == '0) begin
            w_len = LEN_W'(1);
        end else if (r_pat_len > MAX_LEN) begin
            w_len = MAX_LEN;
        end
    end

    assign w_pattern = {r_pat_hi, r_pat_lo};

    // Row of window cells; cell 0 holds the newest character
    assign w_chain[0] = 1'b1;
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        t_cell_ctl        w_ctl;
        logic [LEN_W-1:0] w_idx;

        // cell k pairs with pattern byte len-1-k
        assign w_idx        = w_len - LEN_W'(k) - LEN_W'(1);
        assign w_ctl.shift  = w_is_char;
        assign w_ctl.active = LEN_W'(k) < w_len;

        if (k == 0) begin : g_head
            assign w_cell_in[k] = i_char_byte;
        end else begin : g_body
            assign w_cell_in[k] = w_cell_q[k-1];
        end

        wlsc_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_char         (w_cell_in[k]),
            .i_pattern_byte (w_pattern[w_idx[3:0]*CHAR_W +: CHAR_W]),
            .i_match        (w_chain[k]),
            .o_char         (w_cell_q[k]),
            .o_match        (w_chain[k+1])
        );
    end

    // Character count for the new window, saturating at the window depth
    always_comb begin
        n_chars = r_chars;
        if (w_is_char) begin
            if (r_chars < MAX_CNT) begin
                n_chars = r_chars + CNT_W'(1);
            end
        end else if (w_is_end) begin
            n_chars = '0;
        end
    end

    assign w_hit = w_chain[MAX_PATTERN] & (LEN_W'(n_chars) >= w_len);

    // Word flag and list counters
    always_comb begin
        n_word_matched = r_word_matched;
        n_first        = r_first;
        n_second       = r_second;
        if (w_is_char) begin
            n_word_matched = r_word_matched | w_hit;
        end else if (w_is_end) begin
            n_word_matched = 1'b0;
            if (r_word_matched) begin
                if (!i_list_select) begin
                    if (r_first != '1) begin
                        n_first = r_first + COUNT_W'(1);
                    end
                end else begin
                    if (r_second != '1) begin
                        n_second = r_second + COUNT_W'(1);
                    end
                end
            end
        end else if (w_is_report) begin
            n_first  = '0;
            n_second = '0;
        end
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_is_report) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len      <= LEN_W'(1);
            r_pat_lo       <= '0;
            r_pat_hi       <= '0;
            r_chars        <= '0;
            r_word_matched <= 1'b0;
            r_first        <= '0;
            r_second       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PAT_LEN: r_pat_len <= i_cfg_data[LEN_W-1:0];
                    CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                    CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_chars        <= n_chars;
            r_word_matched <= n_word_matched;
            r_first        <= n_first;
            r_second       <= n_second;
            r_out_valid    <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_is_report) begin
            r_out_eq     <= (r_first == r_second);
            r_out_first  <= r_first;
            r_out_second <= r_second;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_counts_equal = r_out_eq;
    assign o_first_count  = r_out_first;
    assign o_second_count = r_out_second;

    // Checks
    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_report |=> (r_first == '0) && (r_second == '0))
        else $error("counts not cleared after report");

    a_report_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_is_report |=> r_out_valid)
        else $error("report beat did not load the result register");

    a_eq_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_eq == (r_out_first == r_out_second)))
        else $error("equality flag disagrees with counts");

    a_chars_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chars <= MAX_CNT)
        else $error("character count above window depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !w_is_report)
        else $error("pending result overwritten");

endmodule
